/* design/ordered_convex_hull_scan_assert.svh */
// assertion macros for the ordered convex hull scan
// included by the top level, needs nothing else
`ifndef ORDERED_CONVEX_HULL_SCAN_ASSERT_SVH
`define ORDERED_CONVEX_HULL_SCAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OCHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ochs assertion failed");

// next-cycle implication, checked out of reset
`define OCHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ochs assertion failed");

`endif

/* design/ochs_pkg.sv */
// shared constants and types for the ordered convex hull scan
// used by the cross product unit and the top level
package ochs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int COORD_BITS  = 32;

    localparam int FIELD_W = 32;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int HALF_W  = (DIFF_W + 1) / 2;
    localparam int ACC_W   = 2 * DIFF_W + 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
        logic                      last_point;
    } point_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] hull_x;
        logic signed [FIELD_W-1:0] hull_y;
        logic [SIZE_W-1:0]         hull_size;
        logic                      final_vertex;
        logic                      overflowed;
    } hull_out_t;

    typedef struct packed {
        point_t a;
        point_t b;
        point_t c;
    } cross_req_t;

    typedef struct packed {
        logic done;
        logic positive;
        logic zero;
    } cross_res_t;

endpackage

/* design/ochs_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ochs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ochs_cross.sv */
// exact sign of cross(b - a, c - a) with one narrow multiplier
// reused over eight partial products; depends on ochs_pkg
module ochs_cross (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  ochs_pkg::cross_req_t req,
    output ochs_pkg::cross_res_t res
);

    import ochs_pkg::*;

    typedef enum logic [2:0] {C_IDLE, C_MAG, C_MUL, C_DRAIN, C_FIN} cstate_t;

    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_ONE  = 2'd1;
    localparam logic [1:0] SH_TWO  = 2'd2;
    localparam logic [2:0] STEP_LAST = 3'd7;

    cstate_t state_reg, state_next;

    logic signed [DIFF_W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic signed [DIFF_W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [DIFF_W-1:0] mux_reg, mux_next, muy_reg, muy_next;
    logic [DIFF_W-1:0] mvx_reg, mvx_next, mvy_reg, mvy_next;
    logic n1_reg, n1_next, n2_reg, n2_next;
    logic [2:0] step_reg, step_next;
    logic [2*HALF_W-1:0] pp_reg, pp_next;
    logic pp_neg_reg, pp_neg_next, pp_vld_reg, pp_vld_next;
    logic [1:0] pp_sh_reg, pp_sh_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_add;

    logic [DIFF_W-1:0] op1, op2;
    logic [HALF_W-1:0] d1, d2;
    logic [ACC_W-1:0]  ext, addend;

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    // operand digits for the current partial product
    always_comb
    begin
        op1 = step_reg[2] ? muy_reg : mux_reg;
        op2 = step_reg[2] ? mvx_reg : mvy_reg;
        d1  = step_reg[1] ? HALF_W'(op1[DIFF_W-1:HALF_W]) : op1[HALF_W-1:0];
        d2  = step_reg[0] ? HALF_W'(op2[DIFF_W-1:HALF_W]) : op2[HALF_W-1:0];
    end

    always_comb
    begin
        ext = ACC_W'(pp_reg);
        unique case (pp_sh_reg)
            SH_NONE: addend = ext;
            SH_ONE:  addend = ext << HALF_W;
            SH_TWO:  addend = ext << (2 * HALF_W);
            default: addend = '0;
        endcase
        acc_add = pp_neg_reg ? acc_reg - $signed(addend) : acc_reg + $signed(addend);
    end

    always_comb
    begin
        state_next  = state_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        mux_next    = mux_reg;
        muy_next    = muy_reg;
        mvx_next    = mvx_reg;
        mvy_next    = mvy_reg;
        n1_next     = n1_reg;
        n2_next     = n2_reg;
        step_next   = step_reg;
        pp_next     = pp_reg;
        pp_neg_next = pp_neg_reg;
        pp_sh_next  = pp_sh_reg;
        pp_vld_next = pp_vld_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (go)
                begin
                    ux_next    = DIFF_W'(req.b.x) - DIFF_W'(req.a.x);
                    uy_next    = DIFF_W'(req.b.y) - DIFF_W'(req.a.y);
                    vx_next    = DIFF_W'(req.c.x) - DIFF_W'(req.a.x);
                    vy_next    = DIFF_W'(req.c.y) - DIFF_W'(req.a.y);
                    state_next = C_MAG;
                end
            end
            C_MAG:
            begin
                mux_next    = mag(ux_reg);
                muy_next    = mag(uy_reg);
                mvx_next    = mag(vx_reg);
                mvy_next    = mag(vy_reg);
                n1_next     = ux_reg[DIFF_W-1] ^ vy_reg[DIFF_W-1];
                n2_next     = uy_reg[DIFF_W-1] ^ vx_reg[DIFF_W-1];
                acc_next    = '0;
                step_next   = '0;
                pp_vld_next = 1'b0;
                state_next  = C_MUL;
            end
            C_MUL:
            begin
                pp_next     = (2 * HALF_W)'(d1) * (2 * HALF_W)'(d2);
                pp_sh_next  = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
                // second product is subtracted
                pp_neg_next = step_reg[2] ? ~n2_reg : n1_reg;
                pp_vld_next = 1'b1;
                if (pp_vld_reg)
                begin
                    acc_next = acc_add;
                end
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = C_DRAIN;
                end
            end
            C_DRAIN:
            begin
                acc_next    = acc_add;
                pp_vld_next = 1'b0;
                state_next  = C_FIN;
            end
            C_FIN:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            ux_reg     <= '0;
            uy_reg     <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            mux_reg    <= '0;
            muy_reg    <= '0;
            mvx_reg    <= '0;
            mvy_reg    <= '0;
            n1_reg     <= 1'b0;
            n2_reg     <= 1'b0;
            step_reg   <= '0;
            pp_reg     <= '0;
            pp_neg_reg <= 1'b0;
            pp_sh_reg  <= SH_NONE;
            pp_vld_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ux_reg     <= ux_next;
            uy_reg     <= uy_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            mux_reg    <= mux_next;
            muy_reg    <= muy_next;
            mvx_reg    <= mvx_next;
            mvy_reg    <= mvy_next;
            n1_reg     <= n1_next;
            n2_reg     <= n2_next;
            step_reg   <= step_next;
            pp_reg     <= pp_next;
            pp_neg_reg <= pp_neg_next;
            pp_sh_reg  <= pp_sh_next;
            pp_vld_reg <= pp_vld_next;
            acc_reg    <= acc_next;
        end
    end

    assign res.done     = (state_reg == C_FIN);
    assign res.zero     = (acc_reg == '0);
    assign res.positive = ~acc_reg[ACC_W-1] && (acc_reg != '0);

endmodule

/* design/ordered_convex_hull_scan.sv */
// ordered convex hull scan: vertex stack, turn-test sequencer and emitter
// depends on ochs_pkg, ochs_ram, ochs_cross and the assertion macro header
//
// Usage: a point is taken on a clock edge where start is high and busy is low.
// busy stays high while the point is worked on. Each point pops the stack top
// while the top two vertices and the point make no strict left turn, then is
// pushed. A point with last_point set also closes the hull against the first
// vertex and then emits the hull, one vertex per cycle: strobe is high for one
// cycle per beat and result carries the vertex, the hull size, a mark on the
// final beat and the overflow flag. The receiver cannot stall; beats come in
// back-to-back cycles, the final one in the first cycle after busy drops, when
// the next point may already be taken.
// Every turn test runs through the shared multiply unit, 8 partial products,
// after the two stack reads of the top two vertices. Closing reads the first
// vertex, runs the same turn tests with it in place of the point, then the
// collinear test (skipped with fewer than three vertices), then the emission.
// Reset clears the stack count, the point count and the overflow flag; the
// stack memory itself is not cleared.
module ordered_convex_hull_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ochs_pkg::point_in_t   point,
    output logic                  strobe,
    output ochs_pkg::hull_out_t   result
);

    import ochs_pkg::*;

    `include "ordered_convex_hull_scan_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_RDA, S_RDB, S_WAIT, S_PUSH, S_F0,
        S_COLL, S_CLA, S_CLC, S_CLW, S_EMIT
    } state_t;

    localparam logic [1:0] SEEN_FULL = 2'd2;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [1:0]        seen_reg, seen_next;
    logic              ovf_reg, ovf_next;
    logic              closing_reg, closing_next;
    logic              last_reg, last_next;
    point_t            p_reg, p_next, a_reg, a_next, f0_reg, f0_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic              out_vld_reg, out_vld_next, out_fin_reg, out_fin_next;
    logic              out_ovf_reg, out_ovf_next;
    logic [CNT_W-1:0]  out_size_reg, out_size_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    point_t            ram_wdata, rd_data;
    logic [$bits(point_t)-1:0] ram_rdata;

    logic       go;
    cross_req_t req;
    cross_res_t res;

    assign rd_data = point_t'(ram_rdata);

    ochs_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ochs_cross u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .req   (req),
        .res   (res)
    );

    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        seen_next     = seen_reg;
        ovf_next      = ovf_reg;
        closing_next  = closing_reg;
        last_next     = last_reg;
        p_next        = p_reg;
        a_next        = a_reg;
        f0_next       = f0_reg;
        idx_next      = idx_reg;
        size_next     = size_reg;
        out_vld_next  = 1'b0;
        out_fin_next  = 1'b0;
        out_ovf_next  = out_ovf_reg;
        out_size_next = out_size_reg;
        ram_we        = 1'b0;
        ram_waddr     = sp_reg[ADDR_W-1:0];
        ram_wdata     = p_reg;
        ram_raddr     = '0;
        go            = 1'b0;
        req.a         = a_reg;
        req.b         = rd_data;
        req.c         = closing_reg ? f0_reg : p_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    p_next.x   = signed'(point.x_coord[COORD_BITS-1:0]);
                    p_next.y   = signed'(point.y_coord[COORD_BITS-1:0]);
                    last_next  = point.last_point;
                    state_next = (seen_reg == SEEN_FULL) ? S_CHK : S_PUSH;
                end
            end
            S_CHK:
            begin
                if (sp_reg >= CNT_W'(2))
                begin
                    ram_raddr  = ADDR_W'(sp_reg - CNT_W'(2));
                    state_next = S_RDA;
                end
                else
                begin
                    state_next = closing_reg ? S_COLL : S_PUSH;
                end
            end
            S_RDA:
            begin
                a_next     = rd_data;
                ram_raddr  = ADDR_W'(sp_reg - CNT_W'(1));
                state_next = S_RDB;
            end
            S_RDB:
            begin
                go         = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (res.done)
                begin
                    if (!res.positive)
                    begin
                        sp_next    = sp_reg - CNT_W'(1);
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = closing_reg ? S_COLL : S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                if (sp_reg == CNT_W'(STACK_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    ram_we  = 1'b1;
                    sp_next = sp_reg + CNT_W'(1);
                end
                // first vertex is needed for closing
                ram_raddr = '0;
                if (!last_reg)
                begin
                    if (seen_reg != SEEN_FULL)
                    begin
                        seen_next = seen_reg + 2'd1;
                    end
                    state_next = S_IDLE;
                end
                else if (seen_reg == SEEN_FULL)
                begin
                    state_next = S_F0;
                end
                else
                begin
                    idx_next   = '0;
                    size_next  = sp_next;
                    state_next = S_EMIT;
                end
            end
            S_F0:
            begin
                f0_next      = rd_data;
                closing_next = 1'b1;
                state_next   = S_CHK;
            end
            S_COLL:
            begin
                if (sp_reg >= CNT_W'(3))
                begin
                    ram_raddr  = ADDR_W'(1);
                    state_next = S_CLA;
                end
                else
                begin
                    idx_next   = '0;
                    size_next  = sp_reg;
                    state_next = S_EMIT;
                end
            end
            S_CLA:
            begin
                a_next     = rd_data;
                ram_raddr  = ADDR_W'(sp_reg - CNT_W'(1));
                state_next = S_CLC;
            end
            S_CLC:
            begin
                go         = 1'b1;
                req.b      = f0_reg;
                req.c      = rd_data;
                state_next = S_CLW;
            end
            S_CLW:
            begin
                if (res.done)
                begin
                    // first vertex is dropped when collinear with its neighbors
                    idx_next   = res.zero ? ADDR_W'(1) : '0;
                    size_next  = sp_reg - (res.zero ? CNT_W'(1) : '0);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                ram_raddr     = idx_reg;
                out_vld_next  = 1'b1;
                out_size_next = size_reg;
                out_ovf_next  = ovf_reg;
                out_fin_next  = (idx_reg == ADDR_W'(sp_reg - CNT_W'(1)));
                idx_next      = idx_reg + ADDR_W'(1);
                if (out_fin_next)
                begin
                    sp_next      = '0;
                    seen_next    = '0;
                    ovf_next     = 1'b0;
                    closing_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            seen_reg     <= '0;
            ovf_reg      <= 1'b0;
            closing_reg  <= 1'b0;
            last_reg     <= 1'b0;
            p_reg        <= '0;
            a_reg        <= '0;
            f0_reg       <= '0;
            idx_reg      <= '0;
            size_reg     <= '0;
            out_vld_reg  <= 1'b0;
            out_fin_reg  <= 1'b0;
            out_ovf_reg  <= 1'b0;
            out_size_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            seen_reg     <= seen_next;
            ovf_reg      <= ovf_next;
            closing_reg  <= closing_next;
            last_reg     <= last_next;
            p_reg        <= p_next;
            a_reg        <= a_next;
            f0_reg       <= f0_next;
            idx_reg      <= idx_next;
            size_reg     <= size_next;
            out_vld_reg  <= out_vld_next;
            out_fin_reg  <= out_fin_next;
            out_ovf_reg  <= out_ovf_next;
            out_size_reg <= out_size_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = out_vld_reg;

    always_comb
    begin
        result.hull_x       = FIELD_W'($unsigned(rd_data.x));
        result.hull_y       = FIELD_W'($unsigned(rd_data.y));
        result.hull_size    = SIZE_W'(out_size_reg);
        result.final_vertex = out_fin_reg;
        result.overflowed   = out_ovf_reg;
    end

    `OCHS_ASSERT_NXT(a_final_ends_hull, clk, rst_n, strobe && result.final_vertex, !strobe)
    `OCHS_ASSERT_IMP(a_sp_in_range, clk, rst_n, 1'b1, sp_reg <= CNT_W'(STACK_DEPTH))
    `OCHS_ASSERT_IMP(a_size_nonzero, clk, rst_n, strobe, result.hull_size != '0)
    `OCHS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule

/* sim/tb_ordered_convex_hull_scan.sv */
// self-checking bench for ordered_convex_hull_scan: directed point rows, then random hulls
// hull vertices are predicted with exact cross products; needs ochs_pkg and the design files
`timescale 1ns / 100ps

module tb_ordered_convex_hull_scan;
    import ochs_pkg::*;

    localparam int  TARGET_POINTS = 420;
    localparam int  CYCLE_LIMIT   = 2_000_000;
    // worst close: 64 turn tests plus 64 beats
    localparam int  TAIL_CYCLES   = 1200;
    localparam logic signed [FIELD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] C_MAX = 32'sh7fff_ffff;

    typedef logic signed [71:0] wide_t;

    typedef struct {
        point_in_t pt;
        bit        typed;
        hull_out_t vtx;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    point_in_t point;
    logic      strobe;
    hull_out_t result;

    hull_out_t pending_vertices[$];
    point_t    stack_pts[STACK_DEPTH];
    int        stack_len;
    int        pts_in_hull;
    bit        dropped;
    int        errors;
    int        points_sent;
    int        cycles;

    ordered_convex_hull_scan i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .point  (point),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ordered_convex_hull_scan verification failed");
            $finish;
        end
    end

    // sign of cross(b - a, c - a), exact at any coordinate
    function automatic int turn_sign(point_t a, point_t b, point_t c);
        wide_t ax, ay, ux, uy, vx, vy, cr;
        ax = $signed(a.x);
        ay = $signed(a.y);
        ux = $signed(b.x);
        uy = $signed(b.y);
        vx = $signed(c.x);
        vy = $signed(c.y);
        ux = ux - ax;
        uy = uy - ay;
        vx = vx - ax;
        vy = vy - ay;
        cr = ux * vy - uy * vx;
        return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
    endfunction

    task automatic trim_stack(input point_t p);
        while (stack_len >= 2 &&
               turn_sign(stack_pts[stack_len-2], stack_pts[stack_len-1], p) <= 0)
            stack_len--;
    endtask

    // advance the hull for one accepted point; on a last point queue the vertices
    task automatic scan_point(input point_in_t p, input bit record);
        point_t    np;
        hull_out_t v;
        int        first_idx;
        int        n;
        np.x = p.x_coord;
        np.y = p.y_coord;
        first_idx = 0;
        if (pts_in_hull >= 2)
            trim_stack(np);
        if (stack_len >= STACK_DEPTH)
            dropped = 1'b1;
        else
        begin
            stack_pts[stack_len] = np;
            stack_len++;
        end
        if (!p.last_point)
        begin
            if (pts_in_hull < 2)
                pts_in_hull++;
            return;
        end
        if (pts_in_hull >= 2)
        begin
            trim_stack(stack_pts[0]);
            if (stack_len >= 3 &&
                turn_sign(stack_pts[1], stack_pts[0], stack_pts[stack_len-1]) == 0)
                first_idx = 1;
        end
        n = stack_len - first_idx;
        for (int k = 0; k < n; k++)
        begin
            v.hull_x       = stack_pts[first_idx+k].x;
            v.hull_y       = stack_pts[first_idx+k].y;
            v.hull_size    = SIZE_W'(n);
            v.final_vertex = (k == n - 1);
            v.overflowed   = dropped;
            if (record)
                pending_vertices = {pending_vertices, v};
        end
        stack_len   = 0;
        pts_in_hull = 0;
        dropped     = 1'b0;
    endtask

    // beat accepted at the edge where start is high and busy is low
    task automatic send_point(input point_in_t p, input bit record);
        bit quiet;
        quiet = (points_sent >= 160 && points_sent < 260);
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        point <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        scan_point(p, record);
        points_sent++;
    endtask

    task automatic drain_hulls();
        @(negedge clk);
        start <= 1'b0;
        while (pending_vertices.size() != 0)
            @(negedge clk);
    endtask

    function automatic point_in_t mk_point(logic signed [FIELD_W-1:0] x,
                                           logic signed [FIELD_W-1:0] y, logic last);
        point_in_t p;
        p.x_coord    = x;
        p.y_coord    = y;
        p.last_point = last;
        return p;
    endfunction

    function automatic dir_row_t plain_row(logic signed [FIELD_W-1:0] x,
                                           logic signed [FIELD_W-1:0] y, logic last);
        dir_row_t r;
        r.pt    = mk_point(x, y, last);
        r.typed = 1'b0;
        r.vtx   = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic signed [FIELD_W-1:0] x,
                                           logic signed [FIELD_W-1:0] y,
                                           logic signed [FIELD_W-1:0] ex,
                                           logic signed [FIELD_W-1:0] ey,
                                           logic [SIZE_W-1:0] esize, logic efin,
                                           logic eovf);
        dir_row_t r;
        r.pt                 = mk_point(x, y, 1'b1);
        r.typed              = 1'b1;
        r.vtx.hull_x         = ex;
        r.vtx.hull_y         = ey;
        r.vtx.hull_size      = esize;
        r.vtx.final_vertex   = efin;
        r.vtx.overflowed     = eovf;
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    // one hull of len points with the last one marked
    task automatic run_hull(input int len, input int shape);
        point_in_t p;
        int        span;
        int        x0, y0, dx, dy, flip;
        span = ($urandom_range(0, 2) == 0) ? 3 : (($urandom_range(0, 1) == 0) ? 20 : 1000);
        x0   = $urandom_range(0, 2_000_000) - 1_000_000;
        y0   = $urandom_range(0, 2_000_000) - 1_000_000;
        dx   = $urandom_range(1, 1000);
        dy   = $urandom_range(1, 1000);
        flip = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                0:
                begin
                    p.x_coord = $urandom_range(0, 2 * span) - span;
                    p.y_coord = $urandom_range(0, 2 * span) - span;
                end
                1:
                begin
                    // points on a parabola, mostly left turns so the stack grows
                    p.x_coord = x0 + i * dx;
                    p.y_coord = y0 + i * i * dy;
                    if (flip == 0)
                        p.y_coord = -p.y_coord;
                    if ($urandom_range(0, 19) == 0)
                        p.x_coord = $urandom_range(0, 2_000_000) - 1_000_000;
                end
                2:
                begin
                    p.x_coord = $urandom;
                    p.y_coord = $urandom;
                end
                4:
                begin
                    // strictly convex parabola, no turn test pops a point from the stack
                    p.x_coord = x0 + i * dx;
                    p.y_coord = y0 + i * i * dy;
                end
                default:
                begin
                    p.x_coord = edge_coord();
                    p.y_coord = edge_coord();
                end
            endcase
            p.last_point = (i == len - 1);
            send_point(p, 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        hull_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_vertices.size() == 0)
            begin
                errors++;
                $display("%0t unexpected vertex: x=%0d y=%0d size=%0d fin=%0b ovf=%0b",
                         $time, result.hull_x, result.hull_y, result.hull_size,
                         result.final_vertex, result.overflowed);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (result.hull_x !== want.hull_x || result.hull_y !== want.hull_y ||
                    result.hull_size !== want.hull_size ||
                    result.final_vertex !== want.final_vertex ||
                    result.overflowed !== want.overflowed)
                begin
                    errors++;
                    $display("%0t vertex mismatch: expected x=%0d y=%0d size=%0d fin=%0b ovf=%0b",
                             $time, want.hull_x, want.hull_y, want.hull_size,
                             want.final_vertex, want.overflowed);
                    $display("%0t                  actual   x=%0d y=%0d size=%0d fin=%0b ovf=%0b",
                             $time, result.hull_x, result.hull_y, result.hull_size,
                             result.final_vertex, result.overflowed);
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        int       hulls;
        int       len;
        int       shape;
        rst_n       = 1'b0;
        start       = 1'b0;
        point       = '0;
        errors      = 0;
        points_sent = 0;
        cycles      = 0;
        stack_len   = 0;
        pts_in_hull = 0;
        dropped     = 1'b0;
        hulls       = 0;

        // single points right after reset and at the coordinate extremes
        rows = {rows, typed_row(0, 0, 0, 0, 1, 1'b1, 1'b0)};
        rows = {rows, typed_row(C_MIN, C_MAX, C_MIN, C_MAX, 1, 1'b1, 1'b0)};
        rows = {rows, typed_row(C_MAX, C_MIN, C_MAX, C_MIN, 1, 1'b1, 1'b0)};
        // two points are emitted as given
        rows = {rows, plain_row(-1, -1, 1'b0)};
        rows = {rows, plain_row(C_MAX, C_MAX, 1'b1)};
        // extreme triangles, counterclockwise then clockwise
        rows = {rows, plain_row(C_MIN, C_MIN, 1'b0)};
        rows = {rows, plain_row(C_MAX, C_MIN, 1'b0)};
        rows = {rows, plain_row(C_MIN, C_MAX, 1'b1)};
        rows = {rows, plain_row(C_MIN, C_MIN, 1'b0)};
        rows = {rows, plain_row(C_MIN, C_MAX, 1'b0)};
        rows = {rows, plain_row(C_MAX, C_MIN, 1'b1)};
        // all on one line, closing leaves the first point alone
        rows = {rows, plain_row(0, 0, 1'b0)};
        rows = {rows, plain_row(1, 0, 1'b0)};
        rows = {rows, plain_row(2, 0, 1'b0)};
        rows = {rows, plain_row(3, 0, 1'b1)};
        // first point sits on an edge and is dropped by the collinear test
        rows = {rows, plain_row(1, 0, 1'b0)};
        rows = {rows, plain_row(2, 0, 1'b0)};
        rows = {rows, plain_row(2, 2, 1'b0)};
        rows = {rows, plain_row(0, 2, 1'b0)};
        rows = {rows, plain_row(0, 0, 1'b1)};
        // repeated point
        rows = {rows, plain_row(3, 3, 1'b0)};
        rows = {rows, plain_row(3, 3, 1'b0)};
        rows = {rows, plain_row(3, 3, 1'b1)};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send_point(rows[i].pt, !rows[i].typed);
            if (rows[i].typed)
                pending_vertices = {pending_vertices, rows[i].vtx};
        end
        drain_hulls();

        // full stack: a convex run longer than the stack depth
        run_hull(STACK_DEPTH + 4, 4);

        while (points_sent < TARGET_POINTS)
        begin
            shape = $urandom_range(0, 99);
            shape = (shape < 35) ? 0 : ((shape < 60) ? 1 : ((shape < 80) ? 2 : 3));
            if (shape == 1 && $urandom_range(0, 9) == 0)
                len = $urandom_range(40, STACK_DEPTH + 6);
            else if ($urandom_range(0, 11) == 0)
                len = $urandom_range(13, 30);
            else
                len = $urandom_range(1, 12);
            run_hull(len, shape);
            hulls++;
            if (hulls % 15 == 0)
                drain_hulls();
        end

        drain_hulls();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_vertices.size() != 0)
        begin
            errors++;
            $display("%0t %0d expected vertices never arrived", $time,
                     pending_vertices.size());
        end
        if (errors == 0)
            $display("ordered_convex_hull_scan verification clean");
        else
            $display("ordered_convex_hull_scan verification failed");
        $finish;
    end

endmodule
